[design/fcc_pkg.sv]
// shared types, constants and geometry for the floor clearance checker
`timescale 1ns / 1ps
`default_nettype none
package fcc_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 424;
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT + 1);

    // datapath widths
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 10;
    localparam int AVG_W  = 8;
    localparam int CNT_W  = 4;
    localparam int SIDE_W = 2;

    // config port
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int REG_LSB = 2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // sample columns on the floor row
    localparam int CAL_COL_A    = 200;
    localparam int CAL_COL_B    = 256;
    localparam int CAL_COL_C    = 312;
    localparam int LEFT_COL_A   = 102;
    localparam int LEFT_COL_B   = 158;
    localparam int RIGHT_COL_A  = 354;
    localparam int RIGHT_COL_B  = 410;
    localparam int AHEAD_FIRST  = 186;
    localparam int AHEAD_STEP   = 14;
    localparam int AHEAD_POINTS = 10;
    localparam int SIDE_POINTS  = 2;
    localparam int EDGE_MARGIN  = 3;

    // floor(33*s/100) as (s*AVG_MULT) >> AVG_SHIFT, exact for s < 768
    localparam int AVG_MULT   = 173019;
    localparam int AVG_SHIFT  = 19;
    localparam int AVG_PROD_W = 28;

    // floor(333*s/1000) as (s*CAL_MULT) >> CAL_SHIFT, exact for s < 1024
    localparam int CAL_MULT   = 357556086;
    localparam int CAL_SHIFT  = 30;
    localparam int CAL_PROD_W = 40;

    // register reset values
    localparam logic [8:0] FLOOR_ROW_RST    = 9'd300;
    localparam logic [7:0] SIDE_TOL_RST     = 8'd5;
    localparam logic [7:0] AHEAD_TOL_RST    = 8'd4;
    localparam logic [3:0] AHEAD_NEEDED_RST = 4'd6;

    // register indexes
    typedef enum logic [1:0] {
        REG_FLOOR_ROW,
        REG_SIDE_TOL,
        REG_AHEAD_TOL,
        REG_AHEAD_NEEDED
    } fcc_reg_t;

    typedef struct packed {
        logic [8:0] floor_row;
        logic [7:0] side_tolerance;
        logic [7:0] ahead_tolerance;
        logic [3:0] ahead_needed;
    } fcc_cfg_t;

    typedef struct packed {
        logic [7:0] depth_byte;
        logic       frame_end;
    } fcc_pixel_t;

    typedef struct packed {
        logic calibration_frame;
        logic floor_ok;
        logic left_clear;
        logic right_clear;
    } fcc_result_t;

    // what a sample stands for
    typedef struct packed {
        logic cal_pt;
        logic left_pt;
        logic right_pt;
        logic ahead_pt;
        logic last;
    } fcc_tag_t;

    // request from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             zero_avg;
        fcc_tag_t         tag;
    } fcc_req_t;

endpackage
`default_nettype wire

[design/fcc_front.sv]
// front end: pixel position tracking, 3-tap sum and sample classification
`timescale 1ns / 1ps
`default_nettype none
module fcc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fcc_pkg::fcc_cfg_t   cfg,
    input  wire logic            push,
    input  wire fcc_pkg::fcc_pixel_t pixel,
    output logic                 full,
    input  wire logic            q_full,
    output logic                 req_wr,
    output fcc_pkg::fcc_req_t    req
);
    import fcc_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] hist0_reg, hist0_next;
    logic [PIX_W-1:0] hist1_reg, hist1_next;

    logic             accept;
    logic             on_floor;
    logic             edge_row;
    logic [COL_W-1:0] centre;
    logic [COL_W:0]   col_inc;
    logic             is_cal, is_left, is_right, is_ahead;

    // classify the sample centred one column back
    always_comb
    begin
        accept   = push && !q_full;
        full     = q_full;
        on_floor = (32'(row_reg) < FRAME_HEIGHT) &&
                   (32'(row_reg) == 32'(cfg.floor_row)) && (col_reg != '0);
        centre   = col_reg - COL_W'(1);
        edge_row = (32'(cfg.floor_row) < EDGE_MARGIN) ||
                   (32'(cfg.floor_row) + EDGE_MARGIN > FRAME_WIDTH);

        is_ahead = 1'b0;
        for (int i = 0; i < AHEAD_POINTS; i++)
        begin
            if (centre == COL_W'(AHEAD_FIRST + AHEAD_STEP * i))
                is_ahead = 1'b1;
        end
        is_cal   = (centre == COL_W'(CAL_COL_A)) || (centre == COL_W'(CAL_COL_B)) ||
                   (centre == COL_W'(CAL_COL_C));
        is_left  = (centre == COL_W'(LEFT_COL_A)) || (centre == COL_W'(LEFT_COL_B));
        is_right = (centre == COL_W'(RIGHT_COL_A)) || (centre == COL_W'(RIGHT_COL_B));

        req.sum          = SUM_W'(hist1_reg) + SUM_W'(hist0_reg) + SUM_W'(pixel.depth_byte);
        req.zero_avg     = edge_row;
        req.tag.cal_pt   = on_floor && is_cal;
        req.tag.left_pt  = on_floor && is_left;
        req.tag.right_pt = on_floor && is_right;
        req.tag.ahead_pt = on_floor && is_ahead;
        req.tag.last     = pixel.frame_end;

        // only samples that matter and frame ends go to the back end
        req_wr = accept && (pixel.frame_end || req.tag.cal_pt || req.tag.left_pt ||
                            req.tag.right_pt || req.tag.ahead_pt);
    end

    // next position and pixel history
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        hist0_next = hist0_reg;
        hist1_next = hist1_reg;
        col_inc    = {1'b0, col_reg} + (COL_W + 1)'(1);
        if (accept)
        begin
            hist1_next = hist0_reg;
            hist0_next = pixel.depth_byte;
            if (pixel.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (32'(col_inc) >= FRAME_WIDTH)
            begin
                col_next = '0;
                if (32'(row_reg) < FRAME_HEIGHT)
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // position and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            hist0_reg <= '0;
            hist1_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            hist0_reg <= hist0_next;
            hist1_reg <= hist1_next;
        end
    end

endmodule
`default_nettype wire

[design/fcc_queue.sv]
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module fcc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  wire fcc_pkg::fcc_req_t wr_data,
    output logic                   full,
    input  wire logic              rd,
    output fcc_pkg::fcc_req_t      rd_data,
    output logic                   empty
);
    import fcc_pkg::*;

    fcc_req_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_wr, do_rd;

    // pointer and fill bookkeeping
    always_comb
    begin
        full        = (32'(count_reg) == QUEUE_DEPTH);
        empty       = (count_reg == '0);
        do_wr       = wr && !full;
        do_rd       = rd && !empty;
        rd_data     = entries_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (do_rd)
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + QCNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCNT_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

[design/fcc_back.sv]
// back end: average, floor match counting, calibration and result register
`timescale 1ns / 1ps
`default_nettype none
module fcc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fcc_pkg::fcc_cfg_t   cfg,
    input  wire logic                q_empty,
    input  wire fcc_pkg::fcc_req_t   q_data,
    output logic                     q_pop,
    input  wire logic                pop,
    output logic                     empty,
    output fcc_pkg::fcc_result_t     result
);
    import fcc_pkg::*;

    // pipeline registers
    logic              s1_valid_reg, s1_valid_next;
    fcc_req_t          s1_req_reg, s1_req_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [AVG_W-1:0]  s2_avg_reg, s2_avg_next;
    fcc_tag_t          s2_tag_reg, s2_tag_next;
    logic              fin_valid_reg, fin_valid_next;
    logic [SUM_W-1:0]  fin_sum_reg, fin_sum_next;
    logic              fin_left_reg, fin_left_next;
    logic              fin_right_reg, fin_right_next;
    logic              fin_ahead_reg, fin_ahead_next;

    // frame accumulators and calibration state
    logic [SUM_W-1:0]  cal_sum_reg, cal_sum_next;
    logic [SIDE_W-1:0] left_cnt_reg, left_cnt_next;
    logic [SIDE_W-1:0] right_cnt_reg, right_cnt_next;
    logic [CNT_W-1:0]  ahead_cnt_reg, ahead_cnt_next;
    logic [AVG_W-1:0]  dist_reg, dist_next;
    logic [1:0]        held_reg, held_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    fcc_result_t       out_reg, out_next;

    logic                  s2_take, s2_free, s1_move, s1_free, fin_drain;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [AVG_W-1:0]      avg_s1;
    logic [AVG_W-1:0]      dev;
    logic                  side_hit, ahead_hit;
    logic [SUM_W-1:0]      cal_sum_upd;
    logic [SIDE_W-1:0]     left_upd, right_upd;
    logic [CNT_W-1:0]      ahead_upd;
    logic [CAL_PROD_W-1:0] cal_prod;
    logic [AVG_W-1:0]      new_dist;

    // stage handshakes; a pending frame result holds the compare stage
    always_comb
    begin
        s2_take   = s2_valid_reg && !fin_valid_reg;
        s2_free   = !s2_valid_reg || s2_take;
        s1_move   = s1_valid_reg && s2_free;
        s1_free   = !s1_valid_reg || s1_move;
        q_pop     = !q_empty && s1_free;
        fin_drain = fin_valid_reg && (!out_valid_reg || pop);
        empty     = !out_valid_reg;
        result    = out_reg;
    end

    // 3-pixel average by reciprocal multiply
    always_comb
    begin
        avg_prod = AVG_PROD_W'(s1_req_reg.sum) * AVG_PROD_W'(AVG_MULT);
        avg_s1   = s1_req_reg.zero_avg ? '0 : avg_prod[AVG_SHIFT +: AVG_W];
    end

    // deviation from floor distance and updated counts
    always_comb
    begin
        dev         = (s2_avg_reg > dist_reg) ? s2_avg_reg - dist_reg : dist_reg - s2_avg_reg;
        side_hit    = dev < cfg.side_tolerance;
        ahead_hit   = dev < cfg.ahead_tolerance;
        cal_sum_upd = cal_sum_reg + (s2_tag_reg.cal_pt ? SUM_W'(s2_avg_reg) : '0);
        left_upd    = left_cnt_reg + SIDE_W'(s2_tag_reg.left_pt && side_hit);
        right_upd   = right_cnt_reg + SIDE_W'(s2_tag_reg.right_pt && side_hit);
        ahead_upd   = ahead_cnt_reg + CNT_W'(s2_tag_reg.ahead_pt && ahead_hit);
    end

    // calibration distance by reciprocal multiply
    always_comb
    begin
        cal_prod = CAL_PROD_W'(fin_sum_reg) * CAL_PROD_W'(CAL_MULT);
        new_dist = cal_prod[CAL_SHIFT +: AVG_W];
    end

    // next state
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_req_next    = s1_req_reg;
        s2_valid_next  = s2_valid_reg;
        s2_avg_next    = s2_avg_reg;
        s2_tag_next    = s2_tag_reg;
        fin_valid_next = fin_valid_reg;
        fin_sum_next   = fin_sum_reg;
        fin_left_next  = fin_left_reg;
        fin_right_next = fin_right_reg;
        fin_ahead_next = fin_ahead_reg;
        cal_sum_next   = cal_sum_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        ahead_cnt_next = ahead_cnt_reg;
        dist_next      = dist_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // queue to average stage
        if (s1_free)
        begin
            s1_valid_next = q_pop;
            if (q_pop)
                s1_req_next = q_data;
        end

        // average stage to compare stage
        if (s2_free)
        begin
            s2_valid_next = s1_valid_reg;
            if (s1_move)
            begin
                s2_avg_next = avg_s1;
                s2_tag_next = s1_req_reg.tag;
            end
        end

        // compare and count; frame end snapshots the counts
        if (s2_take)
        begin
            if (s2_tag_reg.last)
            begin
                fin_valid_next = 1'b1;
                fin_sum_next   = cal_sum_upd;
                fin_left_next  = (32'(left_upd) == SIDE_POINTS);
                fin_right_next = (32'(right_upd) == SIDE_POINTS);
                fin_ahead_next = ahead_upd > cfg.ahead_needed;
                cal_sum_next   = '0;
                left_cnt_next  = '0;
                right_cnt_next = '0;
                ahead_cnt_next = '0;
            end
            else
            begin
                cal_sum_next   = cal_sum_upd;
                left_cnt_next  = left_upd;
                right_cnt_next = right_upd;
                ahead_cnt_next = ahead_upd;
            end
        end

        // result register
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (fin_drain)
        begin
            fin_valid_next = 1'b0;
            out_valid_next = 1'b1;
            if (dist_reg == '0)
            begin
                dist_next                  = new_dist;
                out_next.calibration_frame = 1'b1;
                out_next.floor_ok          = (new_dist != '0);
                out_next.left_clear        = held_reg[0];
                out_next.right_clear       = held_reg[1];
            end
            else
            begin
                held_next                  = {fin_right_reg, fin_left_reg};
                out_next.calibration_frame = 1'b0;
                out_next.floor_ok          = fin_ahead_reg;
                out_next.left_clear        = fin_left_reg;
                out_next.right_clear       = fin_right_reg;
            end
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            cal_sum_reg   <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            ahead_cnt_reg <= '0;
            dist_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            fin_valid_reg <= fin_valid_next;
            cal_sum_reg   <= cal_sum_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            ahead_cnt_reg <= ahead_cnt_next;
            dist_reg      <= dist_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_req_reg    <= s1_req_next;
        s2_avg_reg    <= s2_avg_next;
        s2_tag_reg    <= s2_tag_next;
        fin_sum_reg   <= fin_sum_next;
        fin_left_reg  <= fin_left_next;
        fin_right_reg <= fin_right_next;
        fin_ahead_reg <= fin_ahead_next;
        out_reg       <= out_next;
    end

    // a new result only comes from a finished frame
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_valid_reg))
        else $error("result appeared without a finished frame");

    // at most ten center points per frame
    a_ahead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ahead_cnt_reg) <= AHEAD_POINTS)
        else $error("ahead match count out of range");

    // at most two points per side
    a_side_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(left_cnt_reg) <= SIDE_POINTS) && (32'(right_cnt_reg) <= SIDE_POINTS))
        else $error("side match count out of range");

    // no sample of the next frame is counted while a frame result is pending
    a_hold_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg |=> (cal_sum_reg == $past(cal_sum_reg)) &&
                          (ahead_cnt_reg == $past(ahead_cnt_reg)))
        else $error("counts moved while frame result pending");

endmodule
`default_nettype wire

[design/floor_clearance_checker_top.sv]
// top level: config registers, front end, request queue and back end
`timescale 1ns / 1ps
`default_nettype none
// Depth pixels enter in raster order through push/full, one per clock while
// full is low; the block keeps column and row itself and frame_end closes a
// frame. The front end takes a pixel every cycle while full is low and posts
// floor-row samples and frame ends into a four-entry request queue; the back
// end works one request per cycle through a two-stage average and compare
// pipeline while no frame result is pending, and holds its compare stage at
// each frame end until the frame result is moved on. The result is held in a
// one-entry result register until popped; the front end keeps taking pixels
// meanwhile, and full rises only once the queue has filled.
// The first frame after reset (and any frame after a zero calibration) sets
// the floor distance; config registers are at byte offsets 0, 4, 8 and 12.
module floor_clearance_checker_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire fcc_pkg::fcc_pixel_t  pixel,
    output logic                      full,
    output logic                      empty,
    input  wire logic                 pop,
    output fcc_pkg::fcc_result_t      result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [fcc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fcc_pkg::DATA_W-1:0] pwdata,
    output logic [fcc_pkg::DATA_W-1:0]      prdata,
    output logic                      pready
);
    import fcc_pkg::*;

    fcc_cfg_t cfg_reg, cfg_next;
    fcc_reg_t reg_sel;
    logic     cfg_wr;
    logic     q_full, q_empty, q_wr, q_pop;
    fcc_req_t q_wr_data, q_rd_data;

    // register decode and read mux
    always_comb
    begin
        pready   = 1'b1;
        reg_sel  = fcc_reg_t'(paddr[REG_LSB +: 2]);
        cfg_wr   = psel && penable && pwrite && pready;
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_FLOOR_ROW:
            begin
                prdata = DATA_W'(cfg_reg.floor_row);
                if (cfg_wr)
                    cfg_next.floor_row = pwdata[8:0];
            end
            REG_SIDE_TOL:
            begin
                prdata = DATA_W'(cfg_reg.side_tolerance);
                if (cfg_wr)
                    cfg_next.side_tolerance = pwdata[7:0];
            end
            REG_AHEAD_TOL:
            begin
                prdata = DATA_W'(cfg_reg.ahead_tolerance);
                if (cfg_wr)
                    cfg_next.ahead_tolerance = pwdata[7:0];
            end
            REG_AHEAD_NEEDED:
            begin
                prdata = DATA_W'(cfg_reg.ahead_needed);
                if (cfg_wr)
                    cfg_next.ahead_needed = pwdata[3:0];
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_row       <= FLOOR_ROW_RST;
            cfg_reg.side_tolerance  <= SIDE_TOL_RST;
            cfg_reg.ahead_tolerance <= AHEAD_TOL_RST;
            cfg_reg.ahead_needed    <= AHEAD_NEEDED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pixel intake and sample classification
    fcc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .pixel  (pixel),
        .full   (full),
        .q_full (q_full),
        .req_wr (q_wr),
        .req    (q_wr_data)
    );

    // request queue
    fcc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // matching, calibration and results
    fcc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
`default_nettype wire
